[rtl/afs_pkg.sv]
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants for the arithmetic floor sum block
// Fixed field widths of the request and result transactions.
// ----------------------------------------------------------------------------
package afs_pkg;

  // width of each request field on the ports
  localparam int FIELD_W = 32;

  // width of the result sum
  localparam int SUM_W = 64;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [SUM_W-1:0]   sum_t;

endpackage

[rtl/arithmetic_floor_sum.sv]
// ----------------------------------------------------------------------------
// arithmetic_floor_sum: floor sum of an arithmetic progression
// For each request returns sum over i = 0 .. modulus-1 of
// floor((offset + i*step) / modulus), saturated to 64 bits with a flag.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_stall stays high from acceptance
// until the result has been moved into the output register. The request is
// reduced Euclid-style in rounds: whole parts of step and offset are taken,
// their contributions added to the sum, then step and modulus swap roles.
// Every division, multiplication and addition goes through one shared adder;
// divisions and multiplications take one bit per cycle, and a multiplication
// stops early once the multiplier runs out of set bits. There are at most
// about 1.5*W rounds, where W is OPERAND_WIDTH, and a zero modulus skips them
// and goes straight to the result. The result waits in an output register,
// so the next request is accepted as soon as it has been loaded.
// ----------------------------------------------------------------------------
module arithmetic_floor_sum #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  afs_pkg::field_t  in_step,
  input  afs_pkg::field_t  in_modulus,
  input  afs_pkg::field_t  in_offset,
  output logic             out_valid,
  input  logic             out_stall,
  output afs_pkg::sum_t    out_floor_sum,
  output logic             out_overflow
);

  import afs_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * OPERAND_WIDTH;
  // adder width: wide enough for the triangular product and for the sum
  localparam int AW = (3 * OPERAND_WIDTH > SUM_W) ? 3 * OPERAND_WIDTH : SUM_W;
  localparam int CW = $clog2(2 * OPERAND_WIDTH + 1);
  localparam logic [OPERAND_WIDTH-1:0] W_ONE = OPERAND_WIDTH'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST_A,
    ST_DIV_A,
    ST_MUL_NN,
    ST_MUL_TRI,
    ST_ACC_A,
    ST_TEST_B,
    ST_DIV_B,
    ST_MUL_NB,
    ST_ACC_B,
    ST_MUL_Y,
    ST_ADD_B,
    ST_TEST_Y,
    ST_DIV_Y,
    ST_DONE
  } state_t;

  // control and output registers
  state_t          state_r,       state_nxt;
  logic            out_valid_r,   out_valid_nxt;
  sum_t            out_sum_r,     out_sum_nxt;
  logic            out_ovf_r,     out_ovf_nxt;

  // datapath registers
  logic [W-1:0]    a_r,   a_nxt;     // current step
  logic [W-1:0]    m_r,   m_nxt;     // current modulus
  logic [W-1:0]    b_r,   b_nxt;     // current offset
  logic [W-1:0]    n_r,   n_nxt;     // current term count
  logic [W-1:0]    q_r,   q_nxt;     // whole part of step
  logic [W-1:0]    rem_r, rem_nxt;   // divider remainder
  logic [DW-1:0]   dq_r,  dq_nxt;    // dividend out, quotient in
  logic [CW-1:0]   cnt_r, cnt_nxt;   // divider bit count
  logic [AW-1:0]   p_r,   p_nxt;     // product
  logic [AW-1:0]   mc_r,  mc_nxt;    // multiplicand
  logic [W-1:0]    mq_r,  mq_nxt;    // multiplier
  sum_t            acc_r, acc_nxt;   // running sum
  logic            ovf_r, ovf_nxt;   // sticky overflow

  // shared adder
  logic [AW-1:0]   alu_x;
  logic [AW-1:0]   alu_y;
  logic            alu_sub;
  logic [AW:0]     alu_res;

  // step results of the divider and the multiplier
  logic [W:0]      div_t;
  logic            div_ge;
  logic [W-1:0]    rem_step;
  logic [DW-1:0]   dq_step;
  logic [AW-1:0]   p_step;
  logic [AW-1:0]   mc_step;
  logic [W-1:0]    mq_step;
  logic            div_last;
  logic            acc_carry;

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_floor_sum = out_sum_r;
  assign out_overflow  = out_ovf_r;

  // select adder operands for the current step
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_r) inside
      ST_DIV_A, ST_DIV_B, ST_DIV_Y: begin
        alu_x   = AW'(div_t);
        alu_y   = AW'(m_r);
        alu_sub = 1'b1;
      end
      ST_MUL_NN, ST_MUL_TRI, ST_MUL_NB, ST_MUL_Y: begin
        alu_x = p_r;
        alu_y = mc_r;
      end
      ST_ADD_B: begin
        alu_x = p_r;
        alu_y = AW'(b_r);
      end
      ST_ACC_A, ST_ACC_B: begin
        alu_x = AW'(acc_r);
        alu_y = p_r;
      end
      default: begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + (AW + 1)'(alu_sub);

  // restoring division step: carry out means the trial value reached the modulus
  assign div_t    = {rem_r, dq_r[DW-1]};
  assign div_ge   = alu_res[AW];
  assign rem_step = div_ge ? alu_res[W-1:0] : div_t[W-1:0];
  assign dq_step  = {dq_r[DW-2:0], div_ge};
  assign div_last = (cnt_r == CW'(1));

  // shift-add multiplication step, multiplier taken from the low end
  assign p_step  = mq_r[0] ? alu_res[AW-1:0] : p_r;
  assign mc_step = mc_r << 1;
  assign mq_step = mq_r >> 1;

  // anything above the sum width means the sum no longer fits
  assign acc_carry = |alu_res[AW:SUM_W];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    out_ovf_nxt   = out_ovf_r;
    a_nxt   = a_r;
    m_nxt   = m_r;
    b_nxt   = b_r;
    n_nxt   = n_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    cnt_nxt = cnt_r;
    p_nxt   = p_r;
    mc_nxt  = mc_r;
    mq_nxt  = mq_r;
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        // take a new transaction
        if (in_valid) begin
          a_nxt   = in_step[W-1:0];
          m_nxt   = in_modulus[W-1:0];
          b_nxt   = in_offset[W-1:0];
          n_nxt   = in_modulus[W-1:0];
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = (in_modulus[W-1:0] == '0) ? ST_DONE : ST_TEST_A;
        end
      end

      ST_TEST_A: begin
        // reduce the step below the modulus
        if (a_r >= m_r) begin
          rem_nxt   = '0;
          dq_nxt    = {a_r, {W{1'b0}}};
          cnt_nxt   = CW'(W);
          state_nxt = ST_DIV_A;
        end else begin
          state_nxt = ST_TEST_B;
        end
      end

      ST_DIV_A: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r - CW'(1);
        if (div_last) begin
          a_nxt     = rem_step;
          q_nxt     = dq_step[W-1:0];
          p_nxt     = '0;
          mc_nxt    = AW'(n_r);
          mq_nxt    = n_r - W_ONE;
          state_nxt = ST_MUL_NN;
        end
      end

      ST_MUL_NN: begin
        // n*(n-1), then halve it and scale by the whole part of the step
        p_nxt  = p_step;
        mc_nxt = mc_step;
        mq_nxt = mq_step;
        if (mq_step == '0) begin
          p_nxt     = '0;
          mc_nxt    = AW'(p_step[DW-1:1]);
          mq_nxt    = q_r;
          state_nxt = ST_MUL_TRI;
        end
      end

      ST_MUL_TRI: begin
        p_nxt  = p_step;
        mc_nxt = mc_step;
        mq_nxt = mq_step;
        if (mq_step == '0) begin
          state_nxt = ST_ACC_A;
        end
      end

      ST_ACC_A: begin
        acc_nxt   = alu_res[SUM_W-1:0];
        ovf_nxt   = ovf_r | acc_carry;
        state_nxt = ST_TEST_B;
      end

      ST_TEST_B: begin
        // reduce the offset below the modulus
        if (b_r >= m_r) begin
          rem_nxt   = '0;
          dq_nxt    = {b_r, {W{1'b0}}};
          cnt_nxt   = CW'(W);
          state_nxt = ST_DIV_B;
        end else begin
          p_nxt     = '0;
          mc_nxt    = AW'(a_r);
          mq_nxt    = n_r;
          state_nxt = ST_MUL_Y;
        end
      end

      ST_DIV_B: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r - CW'(1);
        if (div_last) begin
          b_nxt     = rem_step;
          p_nxt     = '0;
          mc_nxt    = AW'(n_r);
          mq_nxt    = dq_step[W-1:0];
          state_nxt = ST_MUL_NB;
        end
      end

      ST_MUL_NB: begin
        p_nxt  = p_step;
        mc_nxt = mc_step;
        mq_nxt = mq_step;
        if (mq_step == '0) begin
          state_nxt = ST_ACC_B;
        end
      end

      ST_ACC_B: begin
        acc_nxt   = alu_res[SUM_W-1:0];
        ovf_nxt   = ovf_r | acc_carry;
        p_nxt     = '0;
        mc_nxt    = AW'(a_r);
        mq_nxt    = n_r;
        state_nxt = ST_MUL_Y;
      end

      ST_MUL_Y: begin
        // top term: step*n, plus the offset in the next cycle
        p_nxt  = p_step;
        mc_nxt = mc_step;
        mq_nxt = mq_step;
        if (mq_step == '0) begin
          state_nxt = ST_ADD_B;
        end
      end

      ST_ADD_B: begin
        p_nxt     = alu_res[AW-1:0];
        state_nxt = ST_TEST_Y;
      end

      ST_TEST_Y: begin
        // finish once the top term falls below the modulus
        if (p_r < AW'(m_r)) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = '0;
          dq_nxt    = p_r[DW-1:0];
          cnt_nxt   = CW'(DW);
          state_nxt = ST_DIV_Y;
        end
      end

      ST_DIV_Y: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r - CW'(1);
        if (div_last) begin
          // new count and offset, then swap step and modulus
          n_nxt     = dq_step[W-1:0];
          b_nxt     = rem_step;
          m_nxt     = a_r;
          a_nxt     = m_r;
          state_nxt = ST_TEST_A;
        end
      end

      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = ovf_r ? '1 : acc_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sum_r <= out_sum_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // advance datapath registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    cnt_r <= cnt_nxt;
    p_r   <= p_nxt;
    mc_r  <= mc_nxt;
    mq_r  <= mq_nxt;
    acc_r <= acc_nxt;
    ovf_r <= ovf_nxt;
  end

  // a flagged result is always the saturated value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_sum_r == '1))
    else $error("overflow flagged without a saturated sum");

  // an accepted transaction keeps the input side stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a transaction");

  // the divisor is never zero while dividing
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_A || state_r == ST_DIV_B || state_r == ST_DIV_Y)
      |-> (m_r != '0))
    else $error("division by a zero modulus");

  // the partial remainder stays below the modulus
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_A || state_r == ST_DIV_B || state_r == ST_DIV_Y)
      |-> (rem_r < m_r))
    else $error("divider remainder reached the modulus");

endmodule

[bench/tb_arithmetic_floor_sum.sv]
// ----------------------------------------------------------------------------
// tb_arithmetic_floor_sum: self-checking bench for the floor sum block
// Drives step/modulus/offset requests through the valid/stall input channel,
// predicts each sum with a Euclid-style reduction on wide integers and checks
// every result transaction, in order, against the oldest prediction. Runs a
// directed set of corner requests, then random requests under several idling
// patterns, a long result hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module tb_arithmetic_floor_sum;
  import afs_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned HANG_LIMIT = 200000;
  // length of the long result hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 2500;
  // quiet cycles after the last result, looking for stray transactions
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 66;

  typedef struct packed {
    sum_t floor_sum;
    logic overflow;
  } floor_sum_result_t;

  // Track outstanding requests and check results against the prediction
  class floor_sum_tracker;
    floor_sum_result_t sums_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Sum over i < modulus of floor((offset + i*step) / modulus), saturated
    function floor_sum_result_t floor_sum_of(field_t step_v, field_t modulus_v,
                                             field_t offset_v);
      logic [63:0] a, m, b, n, ymax, tri_n, swap_v;
      logic [127:0] acc;
      logic done;
      floor_sum_result_t res;
      a = {32'd0, step_v};
      m = {32'd0, modulus_v};
      b = {32'd0, offset_v};
      n = m;
      acc = '0;
      done = (m == 0);
      while (!done) begin
        // take the whole part of the step
        if (a >= m) begin
          tri_n = (n * (n - 64'd1)) / 64'd2;
          acc = acc + {64'd0, tri_n} * {64'd0, a / m};
          a = a % m;
        end
        // take the whole part of the offset
        if (b >= m) begin
          acc = acc + {64'd0, n} * {64'd0, b / m};
          b = b % m;
        end
        // swap divisor and step while the top term still reaches the divisor
        ymax = a * n + b;
        if (ymax < m) begin
          done = 1'b1;
        end else begin
          n = ymax / m;
          b = ymax % m;
          swap_v = m;
          m = a;
          a = swap_v;
        end
      end
      if (acc[127:64] != 0) begin
        res.floor_sum = '1;
        res.overflow = 1'b1;
      end else begin
        res.floor_sum = acc[63:0];
        res.overflow = 1'b0;
      end
      return res;
    endfunction

    function void note_request(field_t step_v, field_t modulus_v, field_t offset_v);
      sums_due = {sums_due, floor_sum_of(step_v, modulus_v, offset_v)};
    endfunction

    function void check_result(sum_t got_sum, logic got_overflow);
      floor_sum_result_t want;
      if (sums_due.size() == 0) begin
        $error("result with no request outstanding: floor_sum %0d overflow %0b",
               got_sum, got_overflow);
        mismatches++;
        return;
      end
      want = sums_due.pop_front();
      if (got_sum !== want.floor_sum) begin
        $error("floor_sum mismatch: expected %0d, actual %0d", want.floor_sum, got_sum);
        mismatches++;
      end
      if (got_overflow !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, got_overflow);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return sums_due.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  field_t in_step = '0;
  field_t in_modulus = '0;
  field_t in_offset = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  sum_t   out_floor_sum;
  logic   out_overflow;

  floor_sum_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_go = 0;

  arithmetic_floor_sum dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_step       (in_step),
    .in_modulus    (in_modulus),
    .in_offset     (in_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_floor_sum (out_floor_sum),
    .out_overflow  (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request and hold it until the block takes the transaction
  task automatic offer(field_t step_v, field_t modulus_v, field_t offset_v);
    in_valid   <= 1'b1;
    in_step    <= step_v;
    in_modulus <= modulus_v;
    in_offset  <= offset_v;
    do @(posedge clk); while (in_stall);
    tracker.note_request(step_v, modulus_v, offset_v);
  endtask

  // Drop valid cycle by cycle, per the current idling phase
  task automatic maybe_idle();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold the sender back until every outstanding result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Mostly narrow values to keep requests quick, full width now and then
  function automatic field_t pick_field(bit at_least_one);
    int unsigned bits;
    field_t v;
    if ($urandom_range(99) < 35) begin
      v = $urandom;
    end else begin
      bits = $urandom_range(1, 12);
      v = $urandom & ((32'd1 << bits) - 32'd1);
    end
    if (at_least_one && v == 0) begin
      v = 32'd1;
    end
    return v;
  endfunction

  // Result side: check each transaction, then choose next cycle's stall
  initial begin
    int unsigned hold_off_seen;
    int unsigned held_left;
    hold_off_seen = 0;
    held_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.check_result(out_floor_sum, out_overflow);
      end
      if (held_left > 0) begin
        held_left--;
        out_stall <= 1'b1;
      end else if (hold_off_seen != hold_off_go) begin
        hold_off_seen = hold_off_go;
        held_left = HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: give up after a long stretch with no transaction either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned item;
    int unsigned burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: extremes, zero step, zero modulus, deep reductions
    offer(32'd1, 32'd1, 32'd0);
    offer('1, '1, '1);
    offer(32'd0, 32'd5, 32'd17);
    offer(32'd0, 32'd9, 32'd3);
    offer(32'd7, 32'd0, 32'd9);
    offer(32'd0, 32'd0, 32'd0);
    offer('1, 32'd1, '1);
    offer(32'd1, '1, 32'd0);
    offer(32'd1, '1, '1);
    offer('1, '1, 32'd0);
    offer(32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff);
    offer(32'd2971215073, 32'd1836311903, 32'd0);
    offer(32'd1836311903, 32'd2971215073, 32'd1134903170);
    offer(32'd3, 32'd7, 32'd2);
    offer(32'd7, 32'd3, 32'd100);
    offer(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    offer(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    offer(32'd1, 32'd2, 32'd1);
    drain();

    // random requests under each idling pattern, with a drain in between
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        // long result hold-off while quick requests keep coming, to back up
        if (phase == 1 && item == 20) begin
          hold_off_go++;
          for (burst = 0; burst < 12; burst++) begin
            offer($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 255));
          end
        end
        offer(pick_field(1'b1), pick_field(1'b1), pick_field(1'b0));
        maybe_idle();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
